@@ rtl/core/lapconv_pkg.sv @@
// Shared types and constants for the 3x3 Laplacian convolution unit.
package lapconv_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 4096;
    localparam int MIN_DIM    = 3;
    localparam int MASK_SIZE  = 3;
    localparam int TAP_BITS   = 4;
    localparam int NUM_TAPS   = MASK_SIZE * MASK_SIZE;

    localparam int COLS_W     = 11;
    localparam int ROWS_W     = 13;
    localparam int MASK_W     = NUM_TAPS * TAP_BITS;
    localparam int CFG_W      = MASK_W;
    localparam int CFG_IDX_W  = 2;
    localparam int COL_AW     = $clog2(MAX_COLS);
    localparam int FILL_W     = COL_AW + 1;
    localparam int ROW_CNT_W  = 13;
    localparam int RESULT_W   = 16;
    localparam int OUT_ROW_W  = 12;
    localparam int OUT_COL_W  = 10;
    localparam int PROD_W     = PIXEL_BITS + TAP_BITS + 1;
    localparam int LINE_W     = 2 * PIXEL_BITS;
    localparam int M_DATA_W   = ((RESULT_W + OUT_ROW_W + OUT_COL_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_DATA_W - (RESULT_W + OUT_ROW_W + OUT_COL_W);

    localparam logic [COLS_W-1:0] COLS_RESET = 11'd640;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 13'd480;
    localparam logic [MASK_W-1:0] MASK_RESET = 36'h0_101C_1010;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_COLS  = 2'd0,
        REG_IMAGE_ROWS  = 2'd1,
        REG_MASK_COEFFS = 2'd2
    } cfg_reg_t;

    typedef logic [PIXEL_BITS-1:0] pixel_t;

    // Per-pixel bookkeeping that travels with an item until its sum is formed.
    typedef struct packed {
        logic                 emit;
        logic                 last;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 has_up;
        logic                 has_down;
        logic                 has_left;
        logic                 has_right;
    } tag_t;

    typedef struct packed {
        logic [COL_AW-1:0] addr;
        pixel_t            pixel;
        logic              line_valid;
        tag_t              tag;
    } item_t;

    typedef struct packed {
        logic                       last;
        logic [OUT_COL_W-1:0]       col;
        logic [OUT_ROW_W-1:0]       row;
        logic signed [RESULT_W-1:0] sum;
    } result_t;

endpackage

@@ rtl/core/laplacian_3x3_convolution_unit.sv @@
// Top level of the streaming 3x3 convolution unit with line stores and window.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: pixel_value; s_tuser: flush
//  m_      | out | m_tvalid/m_tready  | m_tdata: filtered_value,out_row,out_col;
//          |     |                    | m_tlast: last_of_frame
//  cfg_    | in  | cfg_wr_en          | cfg_index, cfg_wr_data
//
// One word is taken per clock while the skid register is empty. A word passes
// position counting and the line store read, then the window update and line
// store write, then the 3x3 sum into the output register.
// The single line store memory (one read and one write port) sets the rate.
// Reset clears counters, window and the store fill count; no clearing pass is needed.
// A full skid register stops the pipeline; s_tready is a register output.
module laplacian_3x3_convolution_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] pixel_value
    input  logic                                 s_tuser,   // [0] flush
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [15:0] filtered_value, [27:16] out_row, [37:28] out_col, [39:38] zero
    output logic [lapconv_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                                 m_tlast,
    input  logic                                 cfg_wr_en,
    input  logic [lapconv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lapconv_pkg::CFG_W-1:0]        cfg_wr_data
);

    // Configuration registers.
    logic [lapconv_pkg::COLS_W-1:0] image_cols_reg;
    logic [lapconv_pkg::ROWS_W-1:0] image_rows_reg;
    logic [lapconv_pkg::MASK_W-1:0] mask_coeffs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_cols_reg  <= lapconv_pkg::COLS_RESET;
            image_rows_reg  <= lapconv_pkg::ROWS_RESET;
            mask_coeffs_reg <= lapconv_pkg::MASK_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lapconv_pkg::REG_IMAGE_COLS:
                    image_cols_reg <= cfg_wr_data[lapconv_pkg::COLS_W-1:0];
                lapconv_pkg::REG_IMAGE_ROWS:
                    image_rows_reg <= cfg_wr_data[lapconv_pkg::ROWS_W-1:0];
                lapconv_pkg::REG_MASK_COEFFS:
                    mask_coeffs_reg <= cfg_wr_data[lapconv_pkg::MASK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Effective frame size, clamped to the supported range.
    logic [lapconv_pkg::COLS_W-1:0] cols_eff;
    logic [lapconv_pkg::ROWS_W-1:0] rows_eff;

    always_comb
    begin
        if (image_cols_reg < lapconv_pkg::COLS_W'(lapconv_pkg::MIN_DIM))
            cols_eff = lapconv_pkg::COLS_W'(lapconv_pkg::MIN_DIM);
        else if (image_cols_reg > lapconv_pkg::COLS_W'(lapconv_pkg::MAX_COLS))
            cols_eff = lapconv_pkg::COLS_W'(lapconv_pkg::MAX_COLS);
        else
            cols_eff = image_cols_reg;

        if (image_rows_reg < lapconv_pkg::ROWS_W'(lapconv_pkg::MIN_DIM))
            rows_eff = lapconv_pkg::ROWS_W'(lapconv_pkg::MIN_DIM);
        else if (image_rows_reg > lapconv_pkg::ROWS_W'(lapconv_pkg::MAX_ROWS))
            rows_eff = lapconv_pkg::ROWS_W'(lapconv_pkg::MAX_ROWS);
        else
            rows_eff = image_rows_reg;
    end

    // Pipeline control.
    logic skid_valid_reg;
    logic adv;
    logic accept;

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    // Stage A: raster position of the incoming word.
    logic [lapconv_pkg::COL_AW-1:0]    col_cnt_reg, col_cnt_next;
    logic [lapconv_pkg::ROW_CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [lapconv_pkg::FILL_W-1:0]    fill_reg, fill_next;

    logic [lapconv_pkg::COLS_W-1:0]    c1, c_cur, c_inc, ocol;
    logic [lapconv_pkg::ROW_CNT_W-1:0] r1, r_cur, r_inc, rows_p1, orow, rows_m1;
    logic [lapconv_pkg::COLS_W-1:0]    cols_m1;
    lapconv_pkg::item_t                a_item;

    always_comb
    begin
        rows_p1 = rows_eff + 13'd1;
        rows_m1 = rows_eff - 13'd1;
        cols_m1 = cols_eff - 11'd1;

        c1 = {1'b0, col_cnt_reg};
        r1 = row_cnt_reg;
        if (c1 >= cols_eff)
        begin
            c1 = '0;
            r1 = row_cnt_reg + 13'd1;
        end
        // Past the flush row: start a new frame.
        if ((r1 > rows_p1) || ((r1 == rows_p1) && (c1 != '0)))
        begin
            c_cur = '0;
            r_cur = '0;
        end
        else
        begin
            c_cur = c1;
            r_cur = r1;
        end

        c_inc = c_cur + 11'd1;
        r_inc = r_cur;
        if (c_inc >= cols_eff)
        begin
            c_inc = '0;
            r_inc = r_cur + 13'd1;
        end

        // The result trails by one row and one column.
        if (c_cur == '0)
        begin
            orow = r_cur - 13'd2;
            ocol = cols_m1;
        end
        else
        begin
            orow = r_cur - 13'd1;
            ocol = c_cur - 11'd1;
        end

        a_item.addr       = c_cur[lapconv_pkg::COL_AW-1:0];
        a_item.pixel      = (s_tuser || (r_cur >= rows_eff)) ? '0 : s_tdata;
        a_item.line_valid = (c_cur < fill_reg);
        a_item.tag.emit   = (r_cur >= 13'd2) || ((r_cur == 13'd1) && (c_cur != '0));
        a_item.tag.last   = (orow == rows_m1) && (ocol == cols_m1);
        a_item.tag.row    = orow[lapconv_pkg::OUT_ROW_W-1:0];
        a_item.tag.col    = ocol[lapconv_pkg::OUT_COL_W-1:0];
        a_item.tag.has_up    = (orow != '0);
        a_item.tag.has_down  = (orow != rows_m1);
        a_item.tag.has_left  = (ocol != '0);
        a_item.tag.has_right = (ocol != cols_m1);

        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        fill_next    = fill_reg;
        if (accept)
        begin
            if (a_item.tag.emit && a_item.tag.last)
            begin
                col_cnt_next = '0;
                row_cnt_next = '0;
            end
            else
            begin
                col_cnt_next = c_inc[lapconv_pkg::COL_AW-1:0];
                row_cnt_next = r_inc;
            end
            // Columns are always visited from zero upward, so the written
            // entries form a prefix of the store.
            if (c_cur == fill_reg)
                fill_next = fill_reg + 11'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            fill_reg    <= fill_next;
        end
    end

    // Stage B: line store data arrives, window shifts, store is written back.
    logic               b_valid_reg;
    lapconv_pkg::item_t b_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (adv)
            b_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            b_item_reg <= a_item;
    end

    logic [lapconv_pkg::LINE_W-1:0] line_rdata;
    lapconv_pkg::pixel_t            upper_px, middle_px;
    logic                           b_go;

    // Each store word holds the upper line above the middle line.
    lapconv_ram #(
        .WIDTH (lapconv_pkg::LINE_W),
        .DEPTH (lapconv_pkg::MAX_COLS)
    ) u_line_store (
        .clk   (clk),
        .we    (b_go),
        .waddr (b_item_reg.addr),
        .wdata ({middle_px, b_item_reg.pixel}),
        .re    (accept),
        .raddr (a_item.addr),
        .rdata (line_rdata)
    );

    assign b_go      = adv && b_valid_reg;
    assign upper_px  = b_item_reg.line_valid ?
                       line_rdata[lapconv_pkg::LINE_W-1:lapconv_pkg::PIXEL_BITS] : '0;
    assign middle_px = b_item_reg.line_valid ?
                       line_rdata[lapconv_pkg::PIXEL_BITS-1:0] : '0;

    lapconv_pkg::pixel_t window_reg [lapconv_pkg::MASK_SIZE][lapconv_pkg::MASK_SIZE];
    logic                c_valid_reg;
    lapconv_pkg::tag_t   c_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            for (int i = 0; i < lapconv_pkg::MASK_SIZE; i++)
            begin
                for (int j = 0; j < lapconv_pkg::MASK_SIZE; j++)
                begin
                    window_reg[i][j] <= '0;
                end
            end
        end
        else if (adv)
        begin
            c_valid_reg <= b_valid_reg;
            if (b_valid_reg)
            begin
                for (int i = 0; i < lapconv_pkg::MASK_SIZE; i++)
                begin
                    window_reg[i][0] <= window_reg[i][1];
                    window_reg[i][1] <= window_reg[i][2];
                end
                window_reg[0][2] <= upper_px;
                window_reg[1][2] <= middle_px;
                window_reg[2][2] <= b_item_reg.pixel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_go)
            c_tag_reg <= b_item_reg.tag;
    end

    // Stage C: masked 3x3 sum, one row sum per window row, then the total.
    logic [lapconv_pkg::MASK_SIZE-1:0]        use_row, use_col;
    logic signed [lapconv_pkg::RESULT_W-1:0]  row_sum [lapconv_pkg::MASK_SIZE];
    logic signed [lapconv_pkg::RESULT_W-1:0]  total;
    lapconv_pkg::result_t                     res;

    always_comb
    begin
        logic signed [lapconv_pkg::PROD_W-1:0] prod;
        lapconv_pkg::pixel_t                   px;
        logic signed [lapconv_pkg::TAP_BITS-1:0] coef;
        int                                    k;

        use_row = {c_tag_reg.has_down, 1'b1, c_tag_reg.has_up};
        use_col = {c_tag_reg.has_right, 1'b1, c_tag_reg.has_left};
        total   = '0;
        for (int dy = 0; dy < lapconv_pkg::MASK_SIZE; dy++)
        begin
            row_sum[dy] = '0;
            for (int dx = 0; dx < lapconv_pkg::MASK_SIZE; dx++)
            begin
                k    = dy * lapconv_pkg::MASK_SIZE + dx;
                px   = (use_row[dy] && use_col[dx]) ? window_reg[dy][dx] : '0;
                coef = $signed(mask_coeffs_reg[lapconv_pkg::TAP_BITS*k +: lapconv_pkg::TAP_BITS]);
                prod = $signed({1'b0, px}) * coef;
                row_sum[dy] = row_sum[dy] + lapconv_pkg::RESULT_W'(prod);
            end
        end
        for (int dy = 0; dy < lapconv_pkg::MASK_SIZE; dy++)
        begin
            total = total + row_sum[dy];
        end

        res.sum  = total;
        res.row  = c_tag_reg.row;
        res.col  = c_tag_reg.col;
        res.last = c_tag_reg.last;
    end

    // Output register with a skid register behind it.
    logic                 push;
    logic                 out_valid_reg;
    lapconv_pkg::result_t out_reg, skid_reg;

    assign push = adv && c_valid_reg && c_tag_reg.emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!out_valid_reg || m_tready)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || m_tready)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{lapconv_pkg::M_PAD_W{1'b0}}, out_reg.col, out_reg.row, out_reg.sum};
    assign m_tlast  = out_reg.last;

endmodule

@@ rtl/core/lapconv_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module lapconv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ verif/laplacian_3x3_convolution_unit_tb.sv @@
// Self-checking testbench for the streaming 3x3 convolution unit.
module laplacian_3x3_convolution_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_WORDS   = 120;
    localparam int MIN_PHASES     = 4;

    localparam logic [lapconv_pkg::MASK_W-1:0] MASK_ALL_MAX  = 36'h7_7777_7777;
    localparam logic [lapconv_pkg::MASK_W-1:0] MASK_ALL_MIN  = 36'h8_8888_8888;
    localparam logic [lapconv_pkg::MASK_W-1:0] MASK_ALL_ONES = 36'hF_FFFF_FFFF;
    localparam logic [lapconv_pkg::MASK_W-1:0] MASK_ZERO     = 36'h0_0000_0000;

    typedef enum int {
        PACE_FULL,
        PACE_SEND_GAPS,
        PACE_RECV_STALLS,
        PACE_BOTH
    } pace_t;

    // Mirrors the line stores, window and raster counters to predict each sum.
    class laplace_scoreboard;
        logic [lapconv_pkg::COLS_W-1:0] cols_reg;
        logic [lapconv_pkg::ROWS_W-1:0] rows_reg;
        logic [lapconv_pkg::MASK_W-1:0] mask_reg;
        lapconv_pkg::pixel_t            upper_line [lapconv_pkg::MAX_COLS];
        lapconv_pkg::pixel_t            middle_line [lapconv_pkg::MAX_COLS];
        lapconv_pkg::pixel_t            win [lapconv_pkg::MASK_SIZE][lapconv_pkg::MASK_SIZE];
        int                             row_pos;
        int                             col_pos;
        lapconv_pkg::result_t           expected_sums [$];
        int                             errors;
        int                             results_checked;
        int                             frames_closed;

        function new();
            cols_reg = lapconv_pkg::COLS_RESET;
            rows_reg = lapconv_pkg::ROWS_RESET;
            mask_reg = lapconv_pkg::MASK_RESET;
            foreach (upper_line[i]) upper_line[i] = '0;
            foreach (middle_line[i]) middle_line[i] = '0;
            foreach (win[i, j]) win[i][j] = '0;
            row_pos = 0;
            col_pos = 0;
            errors = 0;
            results_checked = 0;
            frames_closed = 0;
        endfunction

        function int eff_cols();
            int n;
            n = cols_reg;
            if (n < lapconv_pkg::MIN_DIM) n = lapconv_pkg::MIN_DIM;
            if (n > lapconv_pkg::MAX_COLS) n = lapconv_pkg::MAX_COLS;
            return n;
        endfunction

        function int eff_rows();
            int n;
            n = rows_reg;
            if (n < lapconv_pkg::MIN_DIM) n = lapconv_pkg::MIN_DIM;
            if (n > lapconv_pkg::MAX_ROWS) n = lapconv_pkg::MAX_ROWS;
            return n;
        endfunction

        function void set_reg(lapconv_pkg::cfg_reg_t idx,
                              logic [lapconv_pkg::CFG_W-1:0] val);
            case (idx)
                lapconv_pkg::REG_IMAGE_COLS:  cols_reg = val[lapconv_pkg::COLS_W-1:0];
                lapconv_pkg::REG_IMAGE_ROWS:  rows_reg = val[lapconv_pkg::ROWS_W-1:0];
                lapconv_pkg::REG_MASK_COEFFS: mask_reg = val[lapconv_pkg::MASK_W-1:0];
                default: ;
            endcase
        endfunction

        // A register change can leave the position outside the frame; fold it back.
        function void align_position();
            if (col_pos >= eff_cols())
            begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos > eff_rows() + 1 || (row_pos == eff_rows() + 1 && col_pos != 0))
            begin
                row_pos = 0;
                col_pos = 0;
            end
        endfunction

        function int next_row();
            align_position();
            return row_pos;
        endfunction

        function void note_pixel(lapconv_pkg::pixel_t px, logic fl);
            int                   cols;
            int                   rows;
            int                   r;
            int                   c;
            int                   orow;
            int                   ocol;
            int                   pr;
            int                   pc;
            int                   sum;
            int                   k;
            lapconv_pkg::pixel_t  v;
            lapconv_pkg::result_t res;
            cols = eff_cols();
            rows = eff_rows();
            align_position();
            r = row_pos;
            c = col_pos;
            v = (fl || r >= rows) ? '0 : px;

            for (int i = 0; i < lapconv_pkg::MASK_SIZE; i++)
            begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
            win[0][2] = upper_line[c];
            win[1][2] = middle_line[c];
            win[2][2] = v;
            upper_line[c] = middle_line[c];
            middle_line[c] = v;

            col_pos = c + 1;
            if (col_pos >= cols)
            begin
                col_pos = 0;
                row_pos = r + 1;
            end

            // Nothing comes out until the window is centered on pixel (0,0).
            if (r >= 2 || (r == 1 && c >= 1))
            begin
                if (c == 0)
                begin
                    orow = r - 2;
                    ocol = cols - 1;
                end
                else
                begin
                    orow = r - 1;
                    ocol = c - 1;
                end
                sum = 0;
                for (int dy = 0; dy < lapconv_pkg::MASK_SIZE; dy++)
                begin
                    for (int dx = 0; dx < lapconv_pkg::MASK_SIZE; dx++)
                    begin
                        pr = orow + dy - 1;
                        pc = ocol + dx - 1;
                        k  = dy * lapconv_pkg::MASK_SIZE + dx;
                        if (pr >= 0 && pr < rows && pc >= 0 && pc < cols)
                            sum += int'(win[dy][dx]) *
                                   int'($signed(mask_reg[lapconv_pkg::TAP_BITS*k +:
                                                         lapconv_pkg::TAP_BITS]));
                    end
                end
                res.sum  = sum[lapconv_pkg::RESULT_W-1:0];
                res.row  = orow[lapconv_pkg::OUT_ROW_W-1:0];
                res.col  = ocol[lapconv_pkg::OUT_COL_W-1:0];
                res.last = (orow == rows - 1) && (ocol == cols - 1);
                expected_sums.insert(expected_sums.size(), res);
                if (res.last)
                begin
                    row_pos = 0;
                    col_pos = 0;
                    frames_closed++;
                end
            end
        endfunction

        function void check_result(logic [lapconv_pkg::M_DATA_W-1:0] data, logic last);
            lapconv_pkg::result_t              exp;
            logic [lapconv_pkg::RESULT_W-1:0]  got_sum;
            logic [lapconv_pkg::OUT_ROW_W-1:0] got_row;
            logic [lapconv_pkg::OUT_COL_W-1:0] got_col;
            if (expected_sums.size() == 0)
            begin
                $error("result word with nothing predicted: tdata %h tlast %b", data, last);
                errors++;
                return;
            end
            exp = expected_sums.pop_front();
            results_checked++;
            got_sum = data[lapconv_pkg::RESULT_W-1:0];
            got_row = data[lapconv_pkg::RESULT_W +: lapconv_pkg::OUT_ROW_W];
            got_col = data[lapconv_pkg::RESULT_W+lapconv_pkg::OUT_ROW_W +: lapconv_pkg::OUT_COL_W];
            if (got_sum !== exp.sum)
            begin
                $error("filtered_value: expected %0d, got %0d",
                       $signed(exp.sum), $signed(got_sum));
                errors++;
            end
            if (got_row !== exp.row)
            begin
                $error("out_row: expected %0d, got %0d", exp.row, got_row);
                errors++;
            end
            if (got_col !== exp.col)
            begin
                $error("out_col: expected %0d, got %0d", exp.col, got_col);
                errors++;
            end
            if (last !== exp.last)
            begin
                $error("last_of_frame: expected %b, got %b", exp.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [7:0]                        s_tdata = '0;    // [7:0] pixel_value
    logic                              s_tuser = 1'b0;  // [0] flush
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    // [15:0] filtered_value, [27:16] out_row, [37:28] out_col, [39:38] zero
    logic [lapconv_pkg::M_DATA_W-1:0]  m_tdata;
    logic                              m_tlast;
    logic                              cfg_wr_en = 1'b0;
    logic [lapconv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lapconv_pkg::CFG_W-1:0]     cfg_wr_data = '0;

    laplacian_3x3_convolution_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    laplace_scoreboard sb;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int words_sent = 0;

    // Small frame with a flush word inside the frame and a pixel where flushing is due.
    lapconv_pkg::pixel_t corner_px [13] = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
                                            8'hAA, 8'h55, 8'hFF, 8'h00, 8'hFF, 8'h00,
                                            8'h00};
    logic                corner_fl [13] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                                            1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("laplacian_3x3_convolution_unit: mismatch");
                $finish;
            end
        end
    end

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_SEND_GAPS:
            begin
                idle_pct = 55;
                stall_pct = 0;
            end
            PACE_RECV_STALLS:
            begin
                idle_pct = 0;
                stall_pct = 55;
            end
            PACE_BOTH:
            begin
                idle_pct = 25;
                stall_pct = 25;
            end
            default:
            begin
                idle_pct = 0;
                stall_pct = 0;
            end
        endcase
    endtask

    task automatic send_word(input lapconv_pkg::pixel_t px, input logic fl);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= fl;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_pixel(px, fl);
        words_sent++;
    endtask

    // Stop offering words and wait until every predicted result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_sums.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input lapconv_pkg::cfg_reg_t idx,
                             input logic [lapconv_pkg::CFG_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Bits above each register's width carry junk; the block must ignore them.
    task automatic program_regs(input int cols, input int rows,
                                input logic [lapconv_pkg::MASK_W-1:0] mask);
        logic [lapconv_pkg::CFG_W-1:0] wr_val;
        wr_val = lapconv_pkg::CFG_W'({$urandom(), $urandom()});
        wr_val[lapconv_pkg::COLS_W-1:0] = cols[lapconv_pkg::COLS_W-1:0];
        write_reg(lapconv_pkg::REG_IMAGE_COLS, wr_val);
        wr_val = lapconv_pkg::CFG_W'({$urandom(), $urandom()});
        wr_val[lapconv_pkg::ROWS_W-1:0] = rows[lapconv_pkg::ROWS_W-1:0];
        write_reg(lapconv_pkg::REG_IMAGE_ROWS, wr_val);
        write_reg(lapconv_pkg::REG_MASK_COEFFS, mask);
    endtask

    function automatic logic [lapconv_pkg::MASK_W-1:0] pick_mask();
        logic [63:0] bits;
        bits = {$urandom(), $urandom()};
        case ($urandom_range(5))
            0:       return MASK_ALL_MAX;
            1:       return MASK_ALL_MIN;
            2:       return lapconv_pkg::MASK_RESET;
            3:       return ($urandom_range(1) == 0) ? MASK_ZERO : MASK_ALL_ONES;
            default: return bits[lapconv_pkg::MASK_W-1:0];
        endcase
    endfunction

    // Sends pixels, then flush words, until the frame closes or max_words is reached
    // (zero means no cap). Noise puts flush words inside the frame and pixels among
    // the flush words.
    task automatic send_frame(input int noise_pct, input int max_words, input bit solid);
        int                  closed;
        int                  count;
        lapconv_pkg::pixel_t px;
        closed = sb.frames_closed;
        count = 0;
        while (sb.frames_closed == closed && (max_words == 0 || count < max_words))
        begin
            px = solid ? 8'hFF : lapconv_pkg::pixel_t'($urandom_range(255));
            if (sb.next_row() < sb.eff_rows())
                send_word(px, $urandom_range(99) < noise_pct);
            else
                send_word(px, $urandom_range(99) >= noise_pct);
            count++;
        end
    endtask

    initial
    begin
        int                             phase;
        int                             frames;
        int                             noise;
        int                             cut;
        int                             cols;
        int                             rows;
        int                             random_start;
        logic [lapconv_pkg::MASK_W-1:0] mask;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_pace(PACE_FULL);

        // Dimensions below the minimum are clamped to 3x3; the reset mask is in use.
        write_reg(lapconv_pkg::REG_IMAGE_COLS, 2);
        write_reg(lapconv_pkg::REG_IMAGE_ROWS, 0);
        for (int k = 0; k < 13; k++)
            send_word(corner_px[k], corner_fl[k]);
        wait_drained();
        write_reg(lapconv_pkg::REG_IMAGE_COLS, 3);
        write_reg(lapconv_pkg::REG_MASK_COEFFS, MASK_ALL_MIN);
        send_frame(0, 0, 1'b1);

        random_start = words_sent;
        phase = 0;
        while (phase < MIN_PHASES || words_sent - random_start < RANDOM_WORDS)
        begin
            wait_drained();
            set_pace(pace_t'(phase % 4));
            case ($urandom_range(9))
                0:       cols = $urandom_range(2);
                1:       cols = $urandom_range(40, 10);
                default: cols = $urandom_range(9, 3);
            endcase
            rows = ($urandom_range(4) == 0) ? $urandom_range(2) : $urandom_range(6, 3);
            mask = pick_mask();
            program_regs(cols, rows, mask);
            if (phase == 2)
            begin
                // Long receiver hold-off while words keep coming: the input must back up.
                @(negedge clk);
                hold_left = HOLD_CYCLES;
                @(posedge clk);
            end
            noise = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 2);
            frames = $urandom_range(3, 1);
            for (int f = 0; f < frames; f++)
            begin
                if ($urandom_range(99) < 20)
                    wait_drained();
                cut = 0;
                if (f == frames - 1 && $urandom_range(99) < 15)
                    cut = $urandom_range(sb.eff_cols() * sb.eff_rows(), 1);
                send_frame(noise, cut, mask == MASK_ALL_MAX && $urandom_range(2) == 0);
            end
            phase++;
        end

        // Widest rows into the second row, then register changes in the middle of a frame.
        wait_drained();
        set_pace(PACE_FULL);
        program_regs(2047, 8191, lapconv_pkg::MASK_RESET);
        send_frame(0, lapconv_pkg::MAX_COLS + 8, 1'b0);
        wait_drained();
        write_reg(lapconv_pkg::REG_IMAGE_COLS, 5);
        write_reg(lapconv_pkg::REG_IMAGE_ROWS, 3);
        send_frame(0, 0, 1'b0);
        wait_drained();
        write_reg(lapconv_pkg::REG_IMAGE_COLS, 7);
        write_reg(lapconv_pkg::REG_IMAGE_ROWS, 8191);
        send_frame(0, 40, 1'b0);
        wait_drained();
        write_reg(lapconv_pkg::REG_IMAGE_ROWS, 3);
        send_frame(0, 0, 1'b0);

        // Row count above the limit on a narrow frame, cut after sixteen rows.
        wait_drained();
        write_reg(lapconv_pkg::REG_IMAGE_COLS, 3);
        write_reg(lapconv_pkg::REG_IMAGE_ROWS, 8191);
        write_reg(lapconv_pkg::REG_MASK_COEFFS, pick_mask());
        send_frame(5, 48, 1'b0);
        wait_drained();

        $display("Sent %0d words over %0d random phases; checked %0d results, %0d frames closed.",
                 words_sent, phase, sb.results_checked, sb.frames_closed);
        $display("Covered clamped sizes, mask extremes, in-frame flushes and mid-frame changes.");
        if (sb.errors == 0)
            $display("laplacian_3x3_convolution_unit: match");
        else
            $display("laplacian_3x3_convolution_unit: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/lapconv_pkg.sv
rtl/core/lapconv_ram.sv
rtl/core/laplacian_3x3_convolution_unit.sv
verif/laplacian_3x3_convolution_unit_tb.sv
